>>> sv/tilt_compensated_heading_macros.svh
// Assertion macros shared by the heading pipeline.
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH

// Condition implied in the same cycle.
`define HDG_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition implied in the following cycle.
`define HDG_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/hdg_pkg.sv
// Types, constants and angle helpers for the tilt-compensated heading pipeline.
`timescale 1ns / 1ps
package hdg_pkg;

  // Datapath widths.
  localparam int VEC_W     = 64;
  localparam int ROT_W     = 34;
  localparam int ANG_W     = 18;
  localparam int MAG_W     = 16;
  localparam int DEG_W     = 9;
  localparam int ATAN_COUNT = 24;

  typedef logic signed [VEC_W-1:0] vec_word_t;
  typedef logic signed [ROT_W-1:0] rot_word_t;
  typedef logic signed [ANG_W-1:0] angle_t;

  // Angles in turn units, 65536 per full turn.
  localparam angle_t HALF_TURN    = 18'sd32768;
  localparam angle_t QUARTER_TURN = 18'sd16384;
  localparam rot_word_t INV_GAIN  = 34'sd652032874;

  // Micro-rotation angles, atan(2^-i) in turn units.
  localparam angle_t ATAN_TAB [ATAN_COUNT] = '{
    18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
    18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0,
    18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
  };

  // State carried by one vectoring cell.
  typedef struct packed {
    vec_word_t x;
    vec_word_t y;
    angle_t    z;
  } vec_state_t;

  // State carried by one rotation cell.
  typedef struct packed {
    rot_word_t x;
    rot_word_t y;
    angle_t    z;
  } rot_state_t;

  // Signed angle to whole degrees, truncated toward zero.
  function automatic logic signed [DEG_W-1:0] deg_signed(input angle_t a);
    logic signed [26:0] p;
    p = 27'(a) * 27'sd360;
    if (p < 0) begin
      p = p + 27'sd65535;
    end
    return DEG_W'(p >>> 16);
  endfunction

  // Heading angle wrapped into one turn, then to whole degrees.
  function automatic logic [DEG_W-1:0] deg_heading(input angle_t a);
    logic signed [18:0] h;
    logic [26:0] p;
    logic [DEG_W-1:0] d;
    h = (a < 0) ? (19'(a) + 19'sd65536) : 19'(a);
    p = 27'($unsigned(h)) * 27'd360;
    d = p[24:16];
    if (d >= 9'd360) begin
      d = '0;
    end
    return d;
  endfunction

endpackage

>>> sv/hdg_vec_cell.sv
// One vectoring CORDIC cell: a single micro-rotation toward y = 0.
`timescale 1ns / 1ps
module hdg_vec_cell import hdg_pkg::*; #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  vec_state_t    in_st,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output vec_state_t    out_st,
  output logic [SW-1:0] out_side
);

  vec_state_t st_next;

  // Turn toward the x axis and accumulate the step angle.
  always_comb begin
    if (!in_st.y[VEC_W-1]) begin
      st_next.x = in_st.x + (in_st.y >>> STEP);
      st_next.y = in_st.y - (in_st.x >>> STEP);
      st_next.z = in_st.z + ATAN_TAB[STEP];
    end else begin
      st_next.x = in_st.x - (in_st.y >>> STEP);
      st_next.y = in_st.y + (in_st.x >>> STEP);
      st_next.z = in_st.z - ATAN_TAB[STEP];
    end
  end

  // Valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload moves on every advance.
  always_ff @(posedge clk) begin
    if (en) begin
      out_st   <= st_next;
      out_side <= in_side;
    end
  end

endmodule

>>> sv/hdg_rot_cell.sv
// One rotation CORDIC cell: a single micro-rotation that drives z toward zero.
`timescale 1ns / 1ps
module hdg_rot_cell import hdg_pkg::*; #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  rot_state_t    in_st,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output rot_state_t    out_st,
  output logic [SW-1:0] out_side
);

  rot_state_t st_next;

  // Rotate by the step angle in the direction of the remaining angle.
  always_comb begin
    if (!in_st.z[ANG_W-1]) begin
      st_next.x = in_st.x - (in_st.y >>> STEP);
      st_next.y = in_st.y + (in_st.x >>> STEP);
      st_next.z = in_st.z - ATAN_TAB[STEP];
    end else begin
      st_next.x = in_st.x + (in_st.y >>> STEP);
      st_next.y = in_st.y - (in_st.x >>> STEP);
      st_next.z = in_st.z + ATAN_TAB[STEP];
    end
  end

  // Valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload moves on every advance.
  always_ff @(posedge clk) begin
    if (en) begin
      out_st   <= st_next;
      out_side <= in_side;
    end
  end

endmodule

>>> sv/hdg_atan.sv
// Pipelined atan2: quadrant fold, a chain of vectoring cells and a limit stage.
`timescale 1ns / 1ps
module hdg_atan import hdg_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  vec_word_t     in_x,
  input  vec_word_t     in_y,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output angle_t        out_z,
  output logic [SW-1:0] out_side
);

  vec_state_t  fold;
  logic        pre_vld;
  vec_state_t  pre_st;
  logic [SW:0] pre_side;

  logic        chain_vld  [STEPS+1];
  vec_state_t  chain_st   [STEPS+1];
  logic [SW:0] chain_side [STEPS+1];

  angle_t      z_last;
  angle_t      z_lim;

  // Fold the left half-plane into the right one.
  always_comb begin
    fold.x = in_x;
    fold.y = in_y;
    fold.z = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        fold.x = in_y;
        fold.y = -in_x;
        fold.z = QUARTER_TURN;
      end else begin
        fold.x = -in_y;
        fold.y = in_x;
        fold.z = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else if (en) begin
      pre_vld <= in_vld;
    end
  end

  // The zero-vector flag rides with the side data.
  always_ff @(posedge clk) begin
    if (en) begin
      pre_st   <= fold;
      pre_side <= {(in_x == 0) && (in_y == 0), in_side};
    end
  end

  assign chain_vld[0]  = pre_vld;
  assign chain_st[0]   = pre_st;
  assign chain_side[0] = pre_side;

  // Row of micro-rotation cells.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    hdg_vec_cell #(.STEP(i), .SW(SW + 1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (chain_vld[i]),
      .in_st    (chain_st[i]),
      .in_side  (chain_side[i]),
      .out_vld  (chain_vld[i+1]),
      .out_st   (chain_st[i+1]),
      .out_side (chain_side[i+1])
    );
  end

  // Limit to half a turn; a zero vector gives zero.
  always_comb begin
    z_last = chain_st[STEPS].z;
    if (chain_side[STEPS][SW]) begin
      z_lim = '0;
    end else if (z_last > HALF_TURN) begin
      z_lim = HALF_TURN;
    end else if (z_last < -HALF_TURN) begin
      z_lim = -HALF_TURN;
    end else begin
      z_lim = z_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= chain_vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_z    <= z_lim;
      out_side <= chain_side[STEPS][SW-1:0];
    end
  end

endmodule

>>> sv/hdg_sincos.sv
// Pipelined sine and cosine: quarter-turn fold and a chain of rotation cells.
`timescale 1ns / 1ps
module hdg_sincos import hdg_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  angle_t        in_z,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output rot_word_t     out_cos,
  output rot_word_t     out_sin,
  output logic [SW-1:0] out_side
);

  rot_state_t    fold;
  logic          pre_vld;
  rot_state_t    pre_st;
  logic [SW-1:0] pre_side;

  logic          chain_vld  [STEPS+1];
  rot_state_t    chain_st   [STEPS+1];
  logic [SW-1:0] chain_side [STEPS+1];

  // Start on the positive or negative y axis when the angle lies beyond a quarter turn.
  always_comb begin
    fold.x = INV_GAIN;
    fold.y = '0;
    fold.z = in_z;
    if (in_z > QUARTER_TURN) begin
      fold.x = '0;
      fold.y = INV_GAIN;
      fold.z = in_z - QUARTER_TURN;
    end else if (in_z < -QUARTER_TURN) begin
      fold.x = '0;
      fold.y = -INV_GAIN;
      fold.z = in_z + QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else if (en) begin
      pre_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_st   <= fold;
      pre_side <= in_side;
    end
  end

  assign chain_vld[0]  = pre_vld;
  assign chain_st[0]   = pre_st;
  assign chain_side[0] = pre_side;

  // Row of micro-rotation cells.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    hdg_rot_cell #(.STEP(i), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (chain_vld[i]),
      .in_st    (chain_st[i]),
      .in_side  (chain_side[i]),
      .out_vld  (chain_vld[i+1]),
      .out_st   (chain_st[i+1]),
      .out_side (chain_side[i+1])
    );
  end

  assign out_vld  = chain_vld[STEPS];
  assign out_cos  = chain_st[STEPS].x;
  assign out_sin  = chain_st[STEPS].y;
  assign out_side = chain_side[STEPS];

endmodule

>>> sv/tilt_compensated_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Data passes through three atan2 chains, two sine/cosine chains, two multiply
// and two add stages and the output register.
// Throughput is one transfer per cycle; the whole pipeline holds while a result waits.
// Synchronous reset clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`include "tilt_compensated_heading_macros.svh"
module tilt_compensated_heading import hdg_pkg::*; #(
  parameter int ACCEL_BITS   = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ACCEL_BITS-1:0]   accel_x,
  input  logic signed [ACCEL_BITS-1:0]   accel_y,
  input  logic signed [ACCEL_BITS-1:0]   accel_z,
  input  logic signed [MAG_W-1:0]        mag_x,
  input  logic signed [MAG_W-1:0]        mag_y,
  input  logic signed [MAG_W-1:0]        mag_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DEG_W-1:0]               heading_degrees,
  output logic signed [DEG_W-1:0]        roll_degrees,
  output logic signed [DEG_W-1:0]        pitch_degrees
);

  localparam int PA_W = ACCEL_BITS + ROT_W;
  localparam int PM_W = MAG_W + ROT_W;
  localparam int T_W  = PA_W + 1;
  localparam int W_W  = PM_W + 1;
  localparam int WS_W = W_W - 20;
  localparam int M2_W = WS_W + ROT_W;

  typedef struct packed {
    logic signed [ACCEL_BITS-1:0] ax;
    logic signed [ACCEL_BITS-1:0] ay;
    logic signed [ACCEL_BITS-1:0] az;
    logic signed [MAG_W-1:0]      mx;
    logic signed [MAG_W-1:0]      my;
    logic signed [MAG_W-1:0]      mz;
  } raw_t;

  typedef struct packed {
    angle_t roll;
    raw_t   raw;
  } roll_side_t;

  typedef struct packed {
    angle_t                  roll;
    logic signed [MAG_W-1:0] mx;
    logic signed [W_W-1:0]   w;
    logic signed [W_W-1:0]   yb;
  } pitch_side_t;

  typedef struct packed {
    angle_t      pitch;
    pitch_side_t ps;
  } tilt_side_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
  } head_side_t;

  logic adv;

  raw_t        raw_in;
  logic        r_vld;
  angle_t      r_z;
  raw_t        r_side;
  logic        rs_vld;
  rot_word_t   cr;
  rot_word_t   sr;
  roll_side_t  rs_side;

  logic                         m1_vld;
  logic signed [PA_W-1:0]       p_ays;
  logic signed [PA_W-1:0]       p_azc;
  logic signed [PM_W-1:0]       p_mys;
  logic signed [PM_W-1:0]       p_mzc;
  logic signed [PM_W-1:0]       p_mzs;
  logic signed [PM_W-1:0]       p_myc;
  logic signed [ACCEL_BITS-1:0] m1_ax;
  logic signed [MAG_W-1:0]      m1_mx;
  angle_t                       m1_roll;

  logic                         a1_vld;
  logic signed [T_W-1:0]        a1_t;
  logic signed [W_W-1:0]        a1_w;
  logic signed [W_W-1:0]        a1_yb;
  logic signed [ACCEL_BITS-1:0] a1_ax;
  logic signed [MAG_W-1:0]      a1_mx;
  angle_t                       a1_roll;

  logic        p_vld;
  angle_t      p_z;
  pitch_side_t p_side;
  logic        ps_vld;
  rot_word_t   cp;
  rot_word_t   sp;
  tilt_side_t  ps_side;

  logic                    m2_vld;
  logic signed [PM_W-1:0]  m2_a;
  logic signed [M2_W-1:0]  m2_b;
  logic signed [W_W-1:0]   m2_yb;
  angle_t                  m2_roll;
  angle_t                  m2_pitch;

  logic       a2_vld;
  vec_word_t  a2_xh;
  vec_word_t  a2_yh;
  head_side_t a2_side;

  logic       h_vld;
  angle_t     h_z;
  head_side_t h_side;

  // The pipeline holds only while a finished result is not taken.
  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  assign raw_in = '{ax: accel_x, ay: accel_y, az: accel_z, mx: mag_x, my: mag_y, mz: mag_z};

  // Roll from the Y and Z acceleration.
  hdg_atan #(.STEPS(CORDIC_STEPS), .SW($bits(raw_t))) u_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (in_valid),
    .in_x     (VEC_W'(accel_z) <<< 30),
    .in_y     (VEC_W'(accel_y) <<< 30),
    .in_side  (raw_in),
    .out_vld  (r_vld),
    .out_z    (r_z),
    .out_side (r_side)
  );

  hdg_sincos #(.STEPS(CORDIC_STEPS), .SW($bits(roll_side_t))) u_roll_sc (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (r_vld),
    .in_z     (r_z),
    .in_side  ({r_z, r_side}),
    .out_vld  (rs_vld),
    .out_cos  (cr),
    .out_sin  (sr),
    .out_side (rs_side)
  );

  // Products of the roll rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= rs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ays   <= PA_W'(rs_side.raw.ay) * PA_W'(sr);
      p_azc   <= PA_W'(rs_side.raw.az) * PA_W'(cr);
      p_mys   <= PM_W'(rs_side.raw.my) * PM_W'(sr);
      p_mzc   <= PM_W'(rs_side.raw.mz) * PM_W'(cr);
      p_mzs   <= PM_W'(rs_side.raw.mz) * PM_W'(sr);
      p_myc   <= PM_W'(rs_side.raw.my) * PM_W'(cr);
      m1_ax   <= rs_side.raw.ax;
      m1_mx   <= rs_side.raw.mx;
      m1_roll <= rs_side.roll;
    end
  end

  // Sums of the roll rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_vld <= 1'b0;
    end else if (adv) begin
      a1_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_t    <= T_W'(p_ays) + T_W'(p_azc);
      a1_w    <= W_W'(p_mys) + W_W'(p_mzc);
      a1_yb   <= W_W'(p_mzs) - W_W'(p_myc);
      a1_ax   <= m1_ax;
      a1_mx   <= m1_mx;
      a1_roll <= m1_roll;
    end
  end

  // Pitch from the X acceleration and the rolled Y/Z acceleration.
  hdg_atan #(.STEPS(CORDIC_STEPS), .SW($bits(pitch_side_t))) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (a1_vld),
    .in_x     (VEC_W'(a1_t)),
    .in_y     (-(VEC_W'(a1_ax) <<< 30)),
    .in_side  ({a1_roll, a1_mx, a1_w, a1_yb}),
    .out_vld  (p_vld),
    .out_z    (p_z),
    .out_side (p_side)
  );

  hdg_sincos #(.STEPS(CORDIC_STEPS), .SW($bits(tilt_side_t))) u_pitch_sc (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (p_vld),
    .in_z     (p_z),
    .in_side  ({p_z, p_side}),
    .out_vld  (ps_vld),
    .out_cos  (cp),
    .out_sin  (sp),
    .out_side (ps_side)
  );

  // Products of the pitch rotation; the rolled term is cut to Q10 first.
  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (adv) begin
      m2_vld <= ps_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_a     <= PM_W'(ps_side.ps.mx) * PM_W'(cp);
      m2_b     <= M2_W'(WS_W'(ps_side.ps.w >>> 20)) * M2_W'(sp);
      m2_yb    <= ps_side.ps.yb;
      m2_roll  <= ps_side.ps.roll;
      m2_pitch <= ps_side.pitch;
    end
  end

  // Heading operands in Q40.
  always_ff @(posedge clk) begin
    if (rst) begin
      a2_vld <= 1'b0;
    end else if (adv) begin
      a2_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_xh   <= (VEC_W'(m2_a) <<< 10) + VEC_W'(m2_b);
      a2_yh   <= VEC_W'(m2_yb) <<< 10;
      a2_side <= '{roll: m2_roll, pitch: m2_pitch};
    end
  end

  hdg_atan #(.STEPS(CORDIC_STEPS), .SW($bits(head_side_t))) u_head (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (a2_vld),
    .in_x     (a2_xh),
    .in_y     (a2_yh),
    .in_side  (a2_side),
    .out_vld  (h_vld),
    .out_z    (h_z),
    .out_side (h_side)
  );

  // Output register with conversion to degrees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_degrees <= deg_heading(h_z);
      roll_degrees    <= deg_signed(h_side.roll);
      pitch_degrees   <= deg_signed(h_side.pitch);
    end
  end

  // Range checks on the results and the hold of a waiting result.
  `HDG_IMPLIES(a_head_range, out_valid, heading_degrees < 9'd360, "heading out of range")
  `HDG_IMPLIES(a_roll_range, out_valid, (roll_degrees >= -9'sd180) && (roll_degrees <= 9'sd180), "roll out of range")
  `HDG_IMPLIES(a_pitch_range, out_valid, (pitch_degrees >= -9'sd180) && (pitch_degrees <= 9'sd180), "pitch out of range")
  `HDG_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(heading_degrees), "waiting result changed")

endmodule
